>>> rtl/core/grle_pkg.sv
package grle_pkg;

   localparam int PIX_FIELDS  = 8;
   localparam int MAX_RESULTS = 32;
   localparam int PIX_W       = 8;
   localparam int COUNT_W     = 8;
   localparam int BUDGET_W    = 16;
   localparam int VALID_W     = 4;
   localparam int CSR_DATA_W  = 16;

   localparam logic [7:0] ESCAPE_CODE = 8'h41;
   localparam logic [7:0] RUN_BIAS    = 8'h40;
   localparam logic [7:0] FULL_LEVEL  = 8'd64;

   typedef enum logic {
      CSR_FORMAT_VERSION = 1'b0,
      CSR_GLYPH_PIXELS   = 1'b1
   } csr_index_type;

   typedef enum logic {
      ST_IDLE = 1'b0,
      ST_RUN  = 1'b1
   } ctrl_state_type;

   typedef struct packed {
      logic take_input;
      logic run_sel;
      logic load_run;
   } ctrl_cmd_type;

   typedef struct packed {
      logic out_free;
      logic has_pixels;
      logic more;
   } dp_status_type;

   typedef struct packed {
      logic [PIX_FIELDS-1:0][PIX_W-1:0] pixel;
      logic [VALID_W-1:0]               valid_pixels;
      logic                             last_of_item;
      logic                             glyph_done;
   } rsp_word_type;

   // Coverage level 0..64 to 0..255, truncated; anything above 64 saturates.
   function automatic logic [PIX_W-1:0] scale_level(input logic [PIX_W-1:0] level);
      logic [13:0] prod;
      prod = {level[5:0], 8'd0} - {8'd0, level[5:0]};
      if (level >= FULL_LEVEL) begin
         return 8'd255;
      end
      return prod[13:6];
   endfunction

endpackage

>>> rtl/core/grle_ifs.sv
interface grle_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] code_byte;
   logic       glyph_start;

   modport source (output valid, output code_byte, output glyph_start, input ready);
   modport sink (input valid, input code_byte, input glyph_start, output ready);
endinterface

interface grle_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] pixel_0;
   logic [7:0] pixel_1;
   logic [7:0] pixel_2;
   logic [7:0] pixel_3;
   logic [7:0] pixel_4;
   logic [7:0] pixel_5;
   logic [7:0] pixel_6;
   logic [7:0] pixel_7;
   logic [3:0] valid_pixels;
   logic       last_of_item;
   logic       glyph_done;

   modport source (
      output valid, output pixel_0, output pixel_1, output pixel_2, output pixel_3,
      output pixel_4, output pixel_5, output pixel_6, output pixel_7,
      output valid_pixels, output last_of_item, output glyph_done, input ready
   );
   modport sink (
      input valid, input pixel_0, input pixel_1, input pixel_2, input pixel_3,
      input pixel_4, input pixel_5, input pixel_6, input pixel_7,
      input valid_pixels, input last_of_item, input glyph_done, output ready
   );
endinterface

>>> rtl/core/glyph_run_length_expander.sv
// A word's first result is registered as it is accepted and shows in the
// cycle after. A literal byte is taken when the output register is free;
// a run of n pixels fills words of up to LANES pixels, input held meanwhile.
// Bytes that produce nothing (escape, spent budget) take no output word.
// Reset is synchronous and active high: the format returns to 1, the budget,
// last pixel and pending length are cleared, and no result is pending.
module glyph_run_length_expander #(
   parameter int LANES = 8
) (
   input  logic                            clock,
   input  logic                            reset,
   grle_req_if.sink                        req_bus,
   grle_rsp_if.source                      rsp_bus,
   input  logic                            csr_we,
   input  logic                            csr_index,
   input  logic [grle_pkg::CSR_DATA_W-1:0] csr_wdata
);

   grle_pkg::ctrl_cmd_type  cmd;
   grle_pkg::dp_status_type status;
   grle_pkg::rsp_word_type  rsp_word;

   grle_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .status    (status),
      .cmd       (cmd)
   );

   grle_datapath #(
      .LANES (LANES)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .code_byte   (req_bus.code_byte),
      .glyph_start (req_bus.glyph_start),
      .rsp_ready   (rsp_bus.ready),
      .cmd         (cmd),
      .status      (status),
      .rsp_valid   (rsp_bus.valid),
      .rsp_word    (rsp_word)
   );

   assign rsp_bus.pixel_0      = rsp_word.pixel[0];
   assign rsp_bus.pixel_1      = rsp_word.pixel[1];
   assign rsp_bus.pixel_2      = rsp_word.pixel[2];
   assign rsp_bus.pixel_3      = rsp_word.pixel[3];
   assign rsp_bus.pixel_4      = rsp_word.pixel[4];
   assign rsp_bus.pixel_5      = rsp_word.pixel[5];
   assign rsp_bus.pixel_6      = rsp_word.pixel[6];
   assign rsp_bus.pixel_7      = rsp_word.pixel[7];
   assign rsp_bus.valid_pixels = rsp_word.valid_pixels;
   assign rsp_bus.last_of_item = rsp_word.last_of_item;
   assign rsp_bus.glyph_done   = rsp_word.glyph_done;

endmodule

>>> rtl/core/grle_ctrl.sv
module grle_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  grle_pkg::dp_status_type status,
   output grle_pkg::ctrl_cmd_type  cmd
);

   grle_pkg::ctrl_state_type state_ff;
   grle_pkg::ctrl_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= grle_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in       = state_ff;
      req_ready      = 1'b0;
      cmd.take_input = 1'b0;
      cmd.run_sel    = 1'b0;
      cmd.load_run   = 1'b0;
      unique case (state_ff)
         grle_pkg::ST_IDLE: begin
            req_ready      = status.out_free;
            cmd.take_input = req_valid && status.out_free;
            if (cmd.take_input && status.has_pixels && status.more) begin
               state_in = grle_pkg::ST_RUN;
            end
         end
         grle_pkg::ST_RUN: begin
            cmd.run_sel  = 1'b1;
            cmd.load_run = status.out_free;
            if (cmd.load_run && !status.more) begin
               state_in = grle_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = grle_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

>>> rtl/core/grle_datapath.sv
module grle_datapath #(
   parameter int LANES = 8
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_we,
   input  logic                                 csr_index,
   input  logic [grle_pkg::CSR_DATA_W-1:0]      csr_wdata,
   input  logic [7:0]                           code_byte,
   input  logic                                 glyph_start,
   input  logic                                 rsp_ready,
   input  grle_pkg::ctrl_cmd_type               cmd,
   output grle_pkg::dp_status_type              status,
   output logic                                 rsp_valid,
   output grle_pkg::rsp_word_type               rsp_word
);

   // Pixels per word, held to the number of pixel fields.
   localparam int LANE_COUNT = (LANES < 1) ? 1 :
                               ((LANES > grle_pkg::PIX_FIELDS) ? grle_pkg::PIX_FIELDS : LANES);
   localparam int RUN_CAP    = LANE_COUNT * grle_pkg::MAX_RESULTS;

   logic                               format_ff;
   logic [grle_pkg::BUDGET_W-1:0]      glyph_pixels_ff;
   logic [grle_pkg::BUDGET_W-1:0]      pixels_left_ff, pixels_left_in;
   logic [grle_pkg::PIX_W-1:0]         prev_ff, prev_in;
   logic                               await_ff, await_in;
   logic [grle_pkg::COUNT_W-1:0]       run_left_ff, run_left_in;
   logic [grle_pkg::PIX_W-1:0]         run_level_ff, run_level_in;
   logic                               rsp_valid_ff, rsp_valid_in;
   grle_pkg::rsp_word_type             rsp_word_ff, rsp_word_in;

   logic [grle_pkg::BUDGET_W-1:0]      left_eff;
   logic [grle_pkg::PIX_W-1:0]         prev_eff;
   logic                               await_eff;
   logic [grle_pkg::COUNT_W-1:0]       req_n;
   logic [grle_pkg::PIX_W-1:0]         req_level;
   logic [grle_pkg::BUDGET_W-1:0]      clip_a;
   logic [grle_pkg::COUNT_W-1:0]       in_count;

   logic [grle_pkg::COUNT_W-1:0]       sel_count;
   logic [grle_pkg::BUDGET_W-1:0]      sel_left;
   logic [grle_pkg::PIX_W-1:0]         sel_level;
   logic [grle_pkg::VALID_W-1:0]       take;
   logic [grle_pkg::COUNT_W-1:0]       remain;
   logic [grle_pkg::BUDGET_W-1:0]      left_after;
   logic [grle_pkg::PIX_W-1:0]         scaled;
   logic                               load_word;

   always_ff @(posedge clock) begin
      if (reset) begin
         format_ff       <= 1'b1;
         glyph_pixels_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            grle_pkg::CSR_FORMAT_VERSION: format_ff       <= csr_wdata[0];
            grle_pkg::CSR_GLYPH_PIXELS:   glyph_pixels_ff <= csr_wdata;
            default:                      format_ff       <= format_ff;
         endcase
      end
   end

   // Decode of the incoming byte against the current state, or the state as reset by a glyph start.
   always_comb begin
      left_eff  = glyph_start ? glyph_pixels_ff : pixels_left_ff;
      prev_eff  = glyph_start ? '0 : prev_ff;
      await_eff = glyph_start ? 1'b0 : await_ff;
      req_n     = '0;
      req_level = prev_eff;
      prev_in   = prev_eff;
      await_in  = 1'b0;
      if (left_eff == '0) begin
         await_in = 1'b0;
      end else if (await_eff) begin
         req_n = code_byte;
      end else if (!format_ff && code_byte == grle_pkg::ESCAPE_CODE) begin
         await_in = 1'b1;
      end else if (format_ff && code_byte >= grle_pkg::ESCAPE_CODE) begin
         req_n = code_byte - grle_pkg::RUN_BIAS;
      end else begin
         prev_in   = code_byte;
         req_level = code_byte;
         req_n     = 8'd1;
      end
      clip_a   = ({8'd0, req_n} < left_eff) ? {8'd0, req_n} : left_eff;
      in_count = (clip_a < grle_pkg::BUDGET_W'(RUN_CAP)) ?
                 clip_a[grle_pkg::COUNT_W-1:0] : grle_pkg::COUNT_W'(RUN_CAP);
   end

   // One word's worth of pixels from either the new byte or the run in progress.
   always_comb begin
      sel_count  = cmd.run_sel ? run_left_ff : in_count;
      sel_left   = cmd.run_sel ? pixels_left_ff : left_eff;
      sel_level  = cmd.run_sel ? run_level_ff : grle_pkg::scale_level(req_level);
      take       = (sel_count < grle_pkg::COUNT_W'(LANE_COUNT)) ?
                   sel_count[grle_pkg::VALID_W-1:0] : grle_pkg::VALID_W'(LANE_COUNT);
      remain     = sel_count - {4'd0, take};
      left_after = sel_left - {12'd0, take};
      scaled     = sel_level;
   end

   assign status.out_free   = !rsp_valid_ff || rsp_ready;
   assign status.has_pixels = sel_count != '0;
   assign status.more       = remain != '0;

   assign load_word = (cmd.take_input && status.has_pixels) || cmd.load_run;

   always_comb begin
      pixels_left_in = pixels_left_ff;
      run_left_in    = run_left_ff;
      run_level_in   = run_level_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_word_in    = rsp_word_ff;
      if (cmd.take_input || cmd.load_run) begin
         pixels_left_in = left_after;
         run_left_in    = remain;
         run_level_in   = scaled;
      end
      if (load_word) begin
         rsp_valid_in = 1'b1;
         for (int j = 0; j < grle_pkg::PIX_FIELDS; j++) begin
            rsp_word_in.pixel[j] = (j < int'(take)) ? scaled : '0;
         end
         rsp_word_in.valid_pixels = take;
         rsp_word_in.last_of_item = remain == '0;
         rsp_word_in.glyph_done   = left_after == '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pixels_left_ff <= '0;
         prev_ff        <= '0;
         await_ff       <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         pixels_left_ff <= pixels_left_in;
         rsp_valid_ff   <= rsp_valid_in;
         if (cmd.take_input) begin
            prev_ff  <= prev_in;
            await_ff <= await_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      run_left_ff  <= run_left_in;
      run_level_ff <= run_level_in;
      rsp_word_ff  <= rsp_word_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

endmodule
